// ----- sv/load_store_buffer_assert.svh -----
// Assertion macros shared by the load/store buffer RTL.
`ifndef LOAD_STORE_BUFFER_ASSERT_SVH
`define LOAD_STORE_BUFFER_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define LSB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition implies another in the same cycle.
`define LSB_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

// ----- sv/lsb_pkg.sv -----
package lsb_pkg;

    localparam int DEPTH_DEF        = 6;
    localparam int MEM_BYTES_DEF    = 65536;
    localparam int ACCESS_DELAY_DEF = 3;

    typedef enum logic [1:0] {
        OP_DISPATCH = 2'd0,
        OP_TICK     = 2'd1,
        OP_FLUSH    = 2'd2,
        OP_NOP      = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        M_NONE = 4'd0,
        M_LB   = 4'd1,
        M_LH   = 4'd2,
        M_LW   = 4'd3,
        M_LBU  = 4'd4,
        M_LHU  = 4'd5,
        M_SB   = 4'd6,
        M_SH   = 4'd7,
        M_SW   = 4'd8
    } t_mode;

    localparam logic [2:0] F3_BYTE  = 3'b000;
    localparam logic [2:0] F3_HALF  = 3'b001;
    localparam logic [2:0] F3_WORD  = 3'b010;
    localparam logic [2:0] F3_BYTEU = 3'b100;

    function automatic t_mode decode_mode(input logic is_store, input logic [2:0] f3);
        t_mode m;
        if (is_store) begin
            m = (f3 == F3_BYTE) ? M_SB : (f3 == F3_HALF) ? M_SH : M_SW;
        end else begin
            m = (f3 == F3_BYTE) ? M_LB : (f3 == F3_HALF) ? M_LH :
                (f3 == F3_WORD) ? M_LW : (f3 == F3_BYTEU) ? M_LBU : M_LHU;
        end
        return m;
    endfunction

    function automatic logic mode_is_load(input t_mode m);
        return (m == M_LB) || (m == M_LH) || (m == M_LW) || (m == M_LBU) || (m == M_LHU);
    endfunction

    function automatic logic [1:0] mode_last_byte(input t_mode m);
        logic [1:0] r;
        case (m)
            M_LH, M_LHU, M_SH: r = 2'd1;
            M_LW, M_SW:        r = 2'd3;
            default:           r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] load_extend(input t_mode m, input logic [31:0] w);
        logic [31:0] r;
        case (m)
            M_LB:    r = {{24{w[7]}}, w[7:0]};
            M_LBU:   r = {24'd0, w[7:0]};
            M_LH:    r = {{16{w[15]}}, w[15:0]};
            M_LHU:   r = {16'd0, w[15:0]};
            M_LW:    r = w;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/lsb_if.sv -----
interface lsb_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic               is_store;
    logic [2:0]         funct3;
    logic [30:0]        serial;
    logic [30:0]        base_tag;
    logic [31:0]        base_value;
    logic signed [11:0] offset;
    logic [30:0]        data_tag;
    logic [31:0]        data_value;
    logic               bus_valid;
    logic [30:0]        bus_tag;
    logic [31:0]        bus_value;

    modport source (
        output valid, opcode, is_store, funct3, serial, base_tag, base_value, offset,
               data_tag, data_value, bus_valid, bus_tag, bus_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, is_store, funct3, serial, base_tag, base_value, offset,
               data_tag, data_value, bus_valid, bus_tag, bus_value,
        output ready
    );
endinterface

interface lsb_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        load_done;
    logic [30:0] done_serial;
    logic [31:0] load_value;
    logic        queue_full;
    logic        queue_empty;

    modport source (
        output valid, accepted, load_done, done_serial, load_value, queue_full, queue_empty,
        input  ready
    );
    modport sink (
        input  valid, accepted, load_done, done_serial, load_value, queue_full, queue_empty,
        output ready
    );
endinterface

// ----- sv/load_store_buffer.sv -----
// In-order load/store queue with an internal byte-wide data memory. One input
// transaction is handled at a time and each yields exactly one result
// transaction. MEM_BYTES must be a power of two: a byte address wraps by
// keeping its low bits. After reset the data memory is zeroed one byte per
// cycle, so no input is taken until the whole memory is cleared. A dispatch,
// an idle tick or an unused opcode goes from the accepting state straight to
// S_RESP; a flush scans the entries one slot per cycle and compacts the
// survivors. A tick that retires the head moves one byte per cycle for a
// store, or one byte per S_RD and S_CAP pair for a load, since the memory
// has a single port with a registered read. The result register is separate
// from the working state, so a waiting result does not hold off the next
// input; the block only holds in S_RESP while an earlier result is still
// not taken.
`include "load_store_buffer_assert.svh"

module load_store_buffer #(
    parameter int DEPTH        = lsb_pkg::DEPTH_DEF,
    parameter int MEM_BYTES    = lsb_pkg::MEM_BYTES_DEF,
    parameter int ACCESS_DELAY = lsb_pkg::ACCESS_DELAY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsb_in_if.sink    i_in,
    lsb_out_if.source o_out
);

    localparam int QW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = $clog2(ACCESS_DELAY + 2);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ST, S_RD, S_CAP, S_FLUSH, S_RESP
    } t_state;

    t_state r_state;

    lsb_pkg::t_mode r_mode  [DEPTH];
    logic [30:0]    r_ser   [DEPTH];
    logic [31:0]    r_base  [DEPTH];
    logic [30:0]    r_bwait [DEPTH];
    logic [31:0]    r_data  [DEPTH];
    logic [30:0]    r_dwait [DEPTH];
    logic [11:0]    r_imm   [DEPTH];
    logic           r_comm  [DEPTH];
    logic [PW-1:0]  r_phase [DEPTH];
    logic [CW-1:0]  r_count;

    logic [31:0]    s_base  [DEPTH];
    logic [30:0]    s_bwait [DEPTH];
    logic [31:0]    s_data  [DEPTH];
    logic [30:0]    s_dwait [DEPTH];
    logic           s_comm  [DEPTH];
    logic           head_rdy;
    logic           head_go;

    logic [CW-1:0]  r_fi;
    logic [CW-1:0]  r_fw;
    logic [30:0]    r_cut;

    logic [AW-1:0]  r_clr;
    lsb_pkg::t_mode r_acc_mode;
    logic [30:0]    r_acc_ser;
    logic [31:0]    r_wd;
    logic [AW-1:0]  r_idx;
    logic [1:0]     r_k;
    logic [31:0]    r_ld;

    logic [AW-1:0]  n_idx;
    logic [31:0]    n_ld;

    logic           m_we;
    logic [AW-1:0]  m_addr;
    logic [7:0]     m_wd;
    logic [7:0]     m_rd;

    logic           r_res_accepted;
    logic           r_res_load_done;
    logic [30:0]    r_res_serial;
    logic [31:0]    r_res_value;

    logic           r_out_valid;
    logic           r_o_accepted;
    logic           r_o_load_done;
    logic [30:0]    r_o_serial;
    logic [31:0]    r_o_value;
    logic           r_o_full;
    logic           r_o_empty;

    // snoop the bus in every slot
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            logic hb;
            logic hd;
            hb = i_in.bus_valid && (r_bwait[i] != 31'd0) && (i_in.bus_tag == r_bwait[i]);
            hd = i_in.bus_valid && (r_dwait[i] != 31'd0) && (i_in.bus_tag == r_dwait[i]);
            s_base[i]  = hb ? i_in.bus_value : r_base[i];
            s_bwait[i] = hb ? 31'd0 : r_bwait[i];
            s_data[i]  = hd ? i_in.bus_value : r_data[i];
            s_dwait[i] = hd ? 31'd0 : r_dwait[i];
            s_comm[i]  = r_comm[i] || (i_in.bus_valid && (i_in.bus_tag == r_ser[i]));
        end
        head_rdy = (s_bwait[0] == 31'd0) && (s_dwait[0] == 31'd0) && s_comm[0];
        head_go  = head_rdy && (r_phase[0] == PW'(ACCESS_DELAY));
    end

    always_comb begin
        n_idx = (r_idx == AW'(MEM_BYTES - 1)) ? '0 : r_idx + AW'(1);
        n_ld  = r_ld;
        n_ld[{r_k, 3'b000} +: 8] = m_rd;
        m_we   = (r_state == S_CLEAR) || (r_state == S_ST);
        m_addr = (r_state == S_CLEAR) ? r_clr : r_idx;
        m_wd   = (r_state == S_CLEAR) ? 8'd0 : r_wd[{r_k, 3'b000} +: 8];
    end

    lsb_dmem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dmem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_addr  (m_addr),
        .i_wdata (m_wd),
        .o_rdata (m_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MEM_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_res_accepted  <= 1'b0;
                        r_res_load_done <= 1'b0;
                        r_res_serial    <= 31'd0;
                        r_res_value     <= 32'd0;
                        r_state         <= S_RESP;
                        case (lsb_pkg::t_op'(i_in.opcode))
                            lsb_pkg::OP_DISPATCH: begin
                                if (r_count < CW'(DEPTH)) begin
                                    r_mode[r_count[QW-1:0]]  <=
                                        lsb_pkg::decode_mode(i_in.is_store, i_in.funct3);
                                    r_ser[r_count[QW-1:0]]   <= i_in.serial;
                                    r_base[r_count[QW-1:0]]  <=
                                        (i_in.base_tag == 31'd0) ? i_in.base_value : 32'd0;
                                    r_bwait[r_count[QW-1:0]] <= i_in.base_tag;
                                    r_data[r_count[QW-1:0]]  <=
                                        (i_in.is_store && i_in.data_tag == 31'd0) ?
                                        i_in.data_value : 32'd0;
                                    r_dwait[r_count[QW-1:0]] <=
                                        i_in.is_store ? i_in.data_tag : 31'd0;
                                    r_imm[r_count[QW-1:0]]   <= i_in.offset;
                                    r_comm[r_count[QW-1:0]]  <= !i_in.is_store;
                                    r_phase[r_count[QW-1:0]] <= '0;
                                    r_count        <= r_count + CW'(1);
                                    r_res_accepted <= 1'b1;
                                end
                            end
                            lsb_pkg::OP_TICK: begin
                                if (r_count != '0) begin
                                    for (int i = 0; i < DEPTH; i++) begin
                                        r_base[i]  <= s_base[i];
                                        r_bwait[i] <= s_bwait[i];
                                        r_data[i]  <= s_data[i];
                                        r_dwait[i] <= s_dwait[i];
                                        r_comm[i]  <= s_comm[i];
                                    end
                                    if (head_go) begin
                                        // advance the queue by one slot
                                        for (int i = 0; i < DEPTH - 1; i++) begin
                                            r_mode[i]  <= r_mode[i+1];
                                            r_ser[i]   <= r_ser[i+1];
                                            r_base[i]  <= s_base[i+1];
                                            r_bwait[i] <= s_bwait[i+1];
                                            r_data[i]  <= s_data[i+1];
                                            r_dwait[i] <= s_dwait[i+1];
                                            r_imm[i]   <= r_imm[i+1];
                                            r_comm[i]  <= s_comm[i+1];
                                            r_phase[i] <= r_phase[i+1];
                                        end
                                        r_count    <= r_count - CW'(1);
                                        r_acc_mode <= r_mode[0];
                                        r_acc_ser  <= r_ser[0];
                                        r_idx      <= AW'(s_base[0] +
                                                      {{20{r_imm[0][11]}}, r_imm[0]});
                                        r_wd       <= s_data[0];
                                        r_k        <= 2'd0;
                                        r_ld       <= 32'd0;
                                        r_state    <= lsb_pkg::mode_is_load(r_mode[0]) ?
                                                      S_RD : S_ST;
                                    end else if (head_rdy) begin
                                        r_phase[0] <= r_phase[0] + PW'(1);
                                    end
                                end
                            end
                            lsb_pkg::OP_FLUSH: begin
                                r_cut   <= i_in.serial;
                                r_fi    <= '0;
                                r_fw    <= '0;
                                r_state <= S_FLUSH;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ST: begin
                    r_idx <= n_idx;
                    r_k   <= r_k + 2'd1;
                    if (r_k == lsb_pkg::mode_last_byte(r_acc_mode)) begin
                        r_state <= S_RESP;
                    end
                end
                S_RD: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_ld  <= n_ld;
                    r_idx <= n_idx;
                    r_k   <= r_k + 2'd1;
                    if (r_k == lsb_pkg::mode_last_byte(r_acc_mode)) begin
                        r_res_load_done <= 1'b1;
                        r_res_serial    <= r_acc_ser;
                        r_res_value     <= lsb_pkg::load_extend(r_acc_mode, n_ld);
                        r_state         <= S_RESP;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_FLUSH: begin
                    if (r_fi == r_count) begin
                        r_count <= r_fw;
                        r_state <= S_RESP;
                    end else begin
                        if (r_ser[r_fi[QW-1:0]] < r_cut) begin
                            r_mode[r_fw[QW-1:0]]  <= r_mode[r_fi[QW-1:0]];
                            r_ser[r_fw[QW-1:0]]   <= r_ser[r_fi[QW-1:0]];
                            r_base[r_fw[QW-1:0]]  <= r_base[r_fi[QW-1:0]];
                            r_bwait[r_fw[QW-1:0]] <= r_bwait[r_fi[QW-1:0]];
                            r_data[r_fw[QW-1:0]]  <= r_data[r_fi[QW-1:0]];
                            r_dwait[r_fw[QW-1:0]] <= r_dwait[r_fi[QW-1:0]];
                            r_imm[r_fw[QW-1:0]]   <= r_imm[r_fi[QW-1:0]];
                            r_comm[r_fw[QW-1:0]]  <= r_comm[r_fi[QW-1:0]];
                            r_phase[r_fw[QW-1:0]] <= r_phase[r_fi[QW-1:0]];
                            r_fw <= r_fw + CW'(1);
                        end
                        r_fi <= r_fi + CW'(1);
                    end
                end
                S_RESP: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_o_accepted  <= r_res_accepted;
                        r_o_load_done <= r_res_load_done;
                        r_o_serial    <= r_res_serial;
                        r_o_value     <= r_res_value;
                        r_o_full      <= (r_count == CW'(DEPTH));
                        r_o_empty     <= (r_count == '0);
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.accepted    = r_o_accepted;
    assign o_out.load_done   = r_o_load_done;
    assign o_out.done_serial = r_o_serial;
    assign o_out.load_value  = r_o_value;
    assign o_out.queue_full  = r_o_full;
    assign o_out.queue_empty = r_o_empty;

    `LSB_ASSERT_ALWAYS(a_count_bound, r_count <= CW'(DEPTH), "queue count above depth")
    `LSB_ASSERT_IMPLY(a_flush_order, r_state == S_FLUSH, r_fw <= r_fi, "flush write ahead")
    `LSB_ASSERT_IMPLY(a_flush_bound, r_state == S_FLUSH, r_fi <= r_count, "flush scan past count")
    `LSB_ASSERT_IMPLY(a_clear_quiet, r_state == S_CLEAR, !r_out_valid, "output during clear")

endmodule

// ----- sv/lsb_dmem.sv -----
module lsb_dmem #(
    parameter int MEM_BYTES = lsb_pkg::MEM_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(MEM_BYTES)-1:0] i_addr,
    input  logic [7:0]                   i_wdata,
    output logic [7:0]                   o_rdata
);

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule

// ----- sim/tb_load_store_buffer.sv -----
`timescale 1ns / 1ps

module tb_load_store_buffer;

    localparam int          NSLOT      = lsb_pkg::DEPTH_DEF;
    localparam int          DELAY      = lsb_pkg::ACCESS_DELAY_DEF;
    localparam int          N_RANDOM   = 1800;
    localparam int          HOLD_START = lsb_pkg::MEM_BYTES_DEF + 1500;
    localparam int          HOLD_LEN   = 400;
    localparam logic [2:0]  F3_HALFU   = 3'b101;
    localparam logic [30:0] TAG_MAX    = 31'h7FFF_FFFF;

    typedef struct {
        lsb_pkg::t_op opcode;
        logic         is_store;
        logic [2:0]   funct3;
        logic [30:0]  serial;
        logic [30:0]  base_tag;
        logic [31:0]  base_value;
        logic [11:0]  offset;
        logic [30:0]  data_tag;
        logic [31:0]  data_value;
        logic         bus_valid;
        logic [30:0]  bus_tag;
        logic [31:0]  bus_value;
    } t_lsq_txn;

    typedef struct {
        logic        accepted;
        logic        load_done;
        logic [30:0] done_serial;
        logic [31:0] load_value;
        logic        queue_full;
        logic        queue_empty;
    } t_lsq_result;

    typedef struct {
        t_lsq_txn    txn;
        bit          typed;
        t_lsq_result res;
    } t_stim_row;

    typedef struct {
        lsb_pkg::t_mode mode;
        logic [30:0]    serial;
        logic [31:0]    base;
        logic [30:0]    base_wait;
        logic [31:0]    data;
        logic [30:0]    data_wait;
        logic [31:0]    imm;
        bit             committed;
        int             phase;
    } t_lsq_slot;

    logic i_clk;
    logic i_rst_n;

    lsb_in_if  in_if ();
    lsb_out_if out_if ();

    load_store_buffer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_lsq_slot   slots [NSLOT];
    int          head_idx;
    int          occupancy;
    bit [7:0]    dmem [65536];
    t_lsq_result pending_results [$];
    int          fail_count = 0;
    int unsigned rx_cycles = 0;
    int          hold_left = 0;
    logic [30:0] next_serial;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("** load_store_buffer: FAILED **");
        $finish;
    end

    function automatic lsb_pkg::t_mode lsq_mode(input logic st, input logic [2:0] f3);
        if (st) begin
            case (f3)
                lsb_pkg::F3_BYTE: return lsb_pkg::M_SB;
                lsb_pkg::F3_HALF: return lsb_pkg::M_SH;
                default:          return lsb_pkg::M_SW;
            endcase
        end
        case (f3)
            lsb_pkg::F3_BYTE:  return lsb_pkg::M_LB;
            lsb_pkg::F3_HALF:  return lsb_pkg::M_LH;
            lsb_pkg::F3_WORD:  return lsb_pkg::M_LW;
            lsb_pkg::F3_BYTEU: return lsb_pkg::M_LBU;
            default:           return lsb_pkg::M_LHU;
        endcase
    endfunction

    function automatic void lsq_snoop(int k, logic bv, logic [30:0] tag, logic [31:0] val);
        bit waiting;
        waiting = (slots[k].base_wait != 0) || (slots[k].data_wait != 0);
        if (!bv) return;
        if (!slots[k].committed && tag == slots[k].serial) slots[k].committed = 1;
        if (slots[k].base_wait != 0 && tag == slots[k].base_wait) begin
            slots[k].base = val;
            slots[k].base_wait = '0;
        end
        if (slots[k].data_wait != 0 && tag == slots[k].data_wait) begin
            slots[k].data = val;
            slots[k].data_wait = '0;
        end
        if (waiting && slots[k].base_wait == 0 && slots[k].data_wait == 0)
            slots[k].phase = 0;
    endfunction

    function automatic t_lsq_result lsq_step(input t_lsq_txn t);
        t_lsq_result r;
        t_lsq_slot   e;
        t_lsq_slot   kept [NSLOT];
        logic [31:0] addr;
        logic [31:0] w;
        int          n;
        int          h;
        r = '{default: '0};
        if (t.opcode == lsb_pkg::OP_DISPATCH) begin
            if (occupancy < NSLOT) begin
                e = '{mode: lsb_pkg::M_NONE, default: '0};
                e.serial    = t.serial;
                e.imm       = {{20{t.offset[11]}}, t.offset};
                e.base_wait = t.base_tag;
                if (t.base_tag == 0) e.base = t.base_value;
                e.mode = lsq_mode(t.is_store, t.funct3);
                if (t.is_store) begin
                    e.data_wait = t.data_tag;
                    if (t.data_tag == 0) e.data = t.data_value;
                end else begin
                    e.committed = 1;
                end
                e.phase = (e.base_wait != 0 || e.data_wait != 0) ? -1 : 0;
                slots[(head_idx + occupancy) % NSLOT] = e;
                occupancy++;
                r.accepted = 1;
            end
        end else if (t.opcode == lsb_pkg::OP_TICK) begin
            if (occupancy != 0) begin
                for (int i = 0; i < occupancy; i++)
                    lsq_snoop((head_idx + i) % NSLOT, t.bus_valid, t.bus_tag, t.bus_value);
                h = head_idx;
                if (slots[h].base_wait == 0 && slots[h].data_wait == 0 &&
                    slots[h].committed) begin
                    if (slots[h].phase == DELAY) begin
                        addr = slots[h].base + slots[h].imm;
                        w = '0;
                        for (int k = 0; k < 4; k++)
                            w[8*k +: 8] = dmem[16'(addr + 32'(k))];
                        case (slots[h].mode)
                            lsb_pkg::M_LB:  w = {{24{w[7]}}, w[7:0]};
                            lsb_pkg::M_LBU: w = {24'd0, w[7:0]};
                            lsb_pkg::M_LH:  w = {{16{w[15]}}, w[15:0]};
                            lsb_pkg::M_LHU: w = {16'd0, w[15:0]};
                            default: ;
                        endcase
                        case (slots[h].mode)
                            lsb_pkg::M_SW: for (int k = 0; k < 4; k++)
                                dmem[16'(addr + 32'(k))] = slots[h].data[8*k +: 8];
                            lsb_pkg::M_SH: for (int k = 0; k < 2; k++)
                                dmem[16'(addr + 32'(k))] = slots[h].data[8*k +: 8];
                            lsb_pkg::M_SB: dmem[16'(addr)] = slots[h].data[7:0];
                            default: begin
                                r.load_done   = 1;
                                r.done_serial = slots[h].serial;
                                r.load_value  = w;
                            end
                        endcase
                        slots[h] = '{mode: lsb_pkg::M_NONE, default: '0};
                        head_idx = (head_idx + 1) % NSLOT;
                        occupancy--;
                    end else if (slots[h].phase >= 0) begin
                        slots[h].phase++;
                    end
                end
            end
        end else if (t.opcode == lsb_pkg::OP_FLUSH) begin
            n = 0;
            for (int i = 0; i < NSLOT; i++) kept[i] = '{mode: lsb_pkg::M_NONE, default: '0};
            for (int i = 0; i < occupancy; i++) begin
                e = slots[(head_idx + i) % NSLOT];
                if (e.serial < t.serial) kept[n++] = e;
            end
            slots = kept;
            head_idx = 0;
            occupancy = n;
        end
        r.queue_full  = (occupancy >= NSLOT);
        r.queue_empty = (occupancy == 0);
        return r;
    endfunction

    function automatic t_lsq_txn random_txn();
        t_lsq_txn    t;
        logic [30:0] live [$];
        int          pick;
        t = '{opcode: lsb_pkg::OP_NOP, default: '0};
        t.bus_value  = $urandom;
        t.base_value = $urandom;
        t.data_value = $urandom;
        t.funct3     = 3'($urandom_range(0, 7));
        t.is_store   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            t.opcode = lsb_pkg::OP_DISPATCH;
            next_serial = 31'(next_serial + $urandom_range(1, 3));
            t.serial = next_serial;
            if ($urandom_range(0, 3) == 0)
                t.base_tag = 31'(next_serial - $urandom_range(1, 6));
            if ($urandom_range(0, 3) == 0)
                t.data_tag = 31'(next_serial - $urandom_range(1, 6));
            if ($urandom_range(0, 9) != 0) t.base_value = $urandom_range(0, 255);
            t.offset = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 64)) : 12'($urandom);
        end else if (pick < 95) begin
            t.opcode = lsb_pkg::OP_TICK;
            for (int i = 0; i < occupancy; i++) begin
                t_lsq_slot e;
                e = slots[(head_idx + i) % NSLOT];
                if (!e.committed) live.push_back(e.serial);
                if (e.base_wait != 0) live.push_back(e.base_wait);
                if (e.data_wait != 0) live.push_back(e.data_wait);
            end
            t.bus_valid = ($urandom_range(0, 9) < 7);
            t.bus_tag = (live.size() != 0 && $urandom_range(0, 4) != 0) ?
                        live[$urandom_range(0, live.size() - 1)] : 31'($urandom);
            if ($urandom_range(0, 3) != 0) t.bus_value = $urandom_range(0, 300);
        end else if (pick < 98) begin
            t.opcode = lsb_pkg::OP_FLUSH;
            t.serial = ($urandom_range(0, 4) == 0) ? 31'($urandom) :
                       31'(next_serial - $urandom_range(0, 12));
        end
        if (t.opcode != lsb_pkg::OP_FLUSH && t.opcode != lsb_pkg::OP_DISPATCH)
            t.serial = 31'($urandom);
        return t;
    endfunction

    task automatic drive_txn(input t_lsq_txn t, input bit typed, input t_lsq_result tr);
        t_lsq_result r;
        in_if.valid      <= 1'b1;
        in_if.opcode     <= t.opcode;
        in_if.is_store   <= t.is_store;
        in_if.funct3     <= t.funct3;
        in_if.serial     <= t.serial;
        in_if.base_tag   <= t.base_tag;
        in_if.base_value <= t.base_value;
        in_if.offset     <= t.offset;
        in_if.data_tag   <= t.data_tag;
        in_if.data_value <= t.data_value;
        in_if.bus_valid  <= t.bus_valid;
        in_if.bus_tag    <= t.bus_tag;
        in_if.bus_value  <= t.bus_value;
        do @(posedge i_clk); while (!in_if.ready);
        r = lsq_step(t);
        pending_results.push_back(typed ? tr : r);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] got);
        if (exp !== got) begin
            $error("%s: expected %h, got %h", name, exp, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_lsq_result exp;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected transaction on output");
                fail_count++;
            end else begin
                exp = pending_results.pop_front();
                check_field("accepted", 32'(exp.accepted), 32'(out_if.accepted));
                check_field("load_done", 32'(exp.load_done), 32'(out_if.load_done));
                check_field("done_serial", 32'(exp.done_serial), 32'(out_if.done_serial));
                check_field("load_value", exp.load_value, out_if.load_value);
                check_field("queue_full", 32'(exp.queue_full), 32'(out_if.queue_full));
                check_field("queue_empty", 32'(exp.queue_empty), 32'(out_if.queue_empty));
            end
        end
    end

    // Receiver: rotate stall patterns, with one long hold to back up the queue.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            rx_cycles <= rx_cycles + 1;
            if (rx_cycles == HOLD_START) hold_left <= HOLD_LEN;
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                out_if.ready <= 1'b0;
            end else begin
                case ((rx_cycles / 256) % 4)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= 1'($urandom_range(0, 1));
                    2: out_if.ready <= (rx_cycles % 7) != 0;
                    default: out_if.ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    initial begin
        t_stim_row   rows [$];
        t_lsq_txn    t;
        t_lsq_result empty_res;
        int          burst;
        int          waited;

        in_if.valid      <= 1'b0;
        in_if.opcode     <= lsb_pkg::OP_NOP;
        in_if.is_store   <= 1'b0;
        in_if.funct3     <= '0;
        in_if.serial     <= '0;
        in_if.base_tag   <= '0;
        in_if.base_value <= '0;
        in_if.offset     <= '0;
        in_if.data_tag   <= '0;
        in_if.data_value <= '0;
        in_if.bus_valid  <= 1'b0;
        in_if.bus_tag    <= '0;
        in_if.bus_value  <= '0;
        head_idx         = 0;
        occupancy        = 0;
        next_serial      = 31'd100;
        for (int i = 0; i < NSLOT; i++) slots[i] = '{mode: lsb_pkg::M_NONE, default: '0};
        for (int i = 0; i < 65536; i++) dmem[i] = '0;

        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        empty_res = '{accepted: 0, load_done: 0, done_serial: 0, load_value: 0,
                      queue_full: 0, queue_empty: 1};
        t = '{opcode: lsb_pkg::OP_TICK, bus_valid: 1, bus_tag: TAG_MAX,
              bus_value: 32'hFFFF_FFFF, default: '0};
        rows.push_back('{t, 1, empty_res});
        t = '{opcode: lsb_pkg::OP_NOP, default: '0};
        rows.push_back('{t, 1, empty_res});
        t = '{opcode: lsb_pkg::OP_FLUSH, serial: TAG_MAX, default: '0};
        rows.push_back('{t, 1, empty_res});
        t = '{opcode: lsb_pkg::OP_DISPATCH, is_store: 1, funct3: lsb_pkg::F3_WORD, serial: 1,
              base_value: 32'h10, data_value: 32'hA5C3_81FF, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_DISPATCH, funct3: lsb_pkg::F3_BYTE, serial: 2,
              base_value: 32'h10, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_DISPATCH, funct3: lsb_pkg::F3_BYTEU, serial: 3,
              base_value: 32'h10, offset: 12'd1, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_DISPATCH, funct3: lsb_pkg::F3_HALF, serial: 4,
              base_tag: 31'h2AAA_AAAA, offset: 12'd2, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_DISPATCH, funct3: F3_HALFU, serial: 5,
              base_value: 32'hFFFF_FFFF, offset: 12'h7FF, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_DISPATCH, funct3: lsb_pkg::F3_WORD, serial: 6,
              base_value: 32'h0000_FFFE, offset: 12'h800, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_DISPATCH, funct3: lsb_pkg::F3_WORD, serial: 7, default: '0};
        rows.push_back('{t, 1, '{accepted: 0, load_done: 0, done_serial: 0, load_value: 0,
                                 queue_full: 1, queue_empty: 0}});
        t = '{opcode: lsb_pkg::OP_TICK, bus_valid: 1, bus_tag: 1, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_TICK, bus_valid: 0, bus_tag: 31'h2AAA_AAAA, default: '0};
        for (int i = 0; i < 4; i++) rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_TICK, bus_valid: 1, bus_tag: 31'h2AAA_AAAA,
              bus_value: 32'h10, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_TICK, default: '0};
        for (int i = 0; i < 4; i++) rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_FLUSH, serial: 5, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_DISPATCH, is_store: 1, funct3: lsb_pkg::F3_HALF, serial: 0,
              base_value: 32'h3, offset: 12'h800, data_tag: TAG_MAX, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_TICK, bus_valid: 1, bus_tag: 0, bus_value: 32'h1234_5678,
              default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_TICK, bus_valid: 1, bus_tag: TAG_MAX,
              bus_value: 32'hFFFF_0000, default: '0};
        rows.push_back('{t, 0, empty_res});
        t = '{opcode: lsb_pkg::OP_FLUSH, serial: 0, default: '0};
        rows.push_back('{t, 1, empty_res});

        foreach (rows[i]) drive_txn(rows[i].txn, rows[i].typed, rows[i].res);

        burst = $urandom_range(1, 20);
        for (int n = 0; n < N_RANDOM; n++) begin
            drive_txn(random_txn(), 0, empty_res);
            burst--;
            if (burst == 0) begin
                if ($urandom_range(0, 2) != 0) begin
                    in_if.valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge i_clk);
                end
                burst = $urandom_range(1, 30);
            end
        end
        in_if.valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("** load_store_buffer: PASSED **");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d results never arrived", pending_results.size());
            $display("** load_store_buffer: FAILED **");
        end
        $finish;
    end

endmodule
